// ----- sv/assert_macros.svh -----
// Assertion macros used by the sequencer core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- sv/lcdnws_pkg.sv -----
// Types and constants of the LCD nibble write sequencer
`default_nettype none

package lcdnws_pkg;

   localparam logic [1:0] MODE_TICK = 2'd0;
   localparam logic [1:0] MODE_CMD  = 2'd1;
   localparam logic [1:0] MODE_DATA = 2'd2;
   localparam logic [1:0] MODE_INIT = 2'd3;

   localparam logic [1:0] CSR_SETUP_WAIT  = 2'd0;
   localparam logic [1:0] CSR_STROBE_WAIT = 2'd1;
   localparam logic [1:0] CSR_INIT_WAIT   = 2'd2;

   localparam logic [15:0] SETUP_WAIT_RESET  = 16'd500;
   localparam logic [15:0] STROBE_WAIT_RESET = 16'd100;
   localparam logic [15:0] INIT_WAIT_RESET   = 16'd1000;

   localparam logic [7:0] CMD_FUNC_SET = 8'h28;
   localparam logic [7:0] CMD_DISP_OFF = 8'h08;
   localparam logic [7:0] CMD_CLEAR    = 8'h01;
   localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
   localparam logic [7:0] CMD_ENTRY   = 8'h06;
   localparam logic [7:0] CMD_LINE2   = 8'hC0;
   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_TERM   = 8'h00;

   localparam logic [3:0] NIB_INIT_A  = 4'h3;
   localparam logic [3:0] NIB_INIT_B  = 4'h2;

   localparam logic [3:0] STEP_NONE   = 4'd0;
   localparam logic [3:0] STEP_FIRST  = 4'd1;
   localparam logic [3:0] STEP_LASTNB = 4'd4;
   localparam logic [3:0] STEP_CMD0   = 4'd5;
   localparam logic [3:0] STEP_CMD1   = 4'd6;
   localparam logic [3:0] STEP_CMD2   = 4'd7;
   localparam logic [3:0] STEP_CMD3   = 4'd8;
   localparam logic [3:0] STEP_CMDEND = 4'd9;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic       reg_select;
      logic       enable_pin;
      logic [3:0] bus_nibble;
      logic       busy_res;
      logic       refused;
   } rsp_type;

   function automatic logic [7:0] init_cmd(input logic [3:0] step);
      logic [7:0] cmd;
      case (step)
         STEP_CMD0:   cmd = CMD_FUNC_SET;
         STEP_CMD1:   cmd = CMD_DISP_OFF;
         STEP_CMD2:   cmd = CMD_CLEAR;
         STEP_CMD3:   cmd = CMD_ENTRY;
         STEP_CMDEND: cmd = CMD_DISP_ON;
         default:     cmd = CMD_FUNC_SET;
      endcase
      return cmd;
   endfunction

endpackage

`default_nettype wire

// ----- sv/lcd_nibble_write_sequencer_core.sv -----
// Top level: 4-bit character LCD write sequencer with registered result
// Usage:
//   req channel: one item per timing tick; mode selects tick, command byte,
//   data character or display initialise, value carries the byte.
//   rsp channel: exactly one result item per request item, showing the
//   RS, E and D7..D4 pin levels after that tick, a busy flag and a flag
//   for a request dropped because a sequence was running.
//   csr channel: writes setup_wait, strobe_wait and init_wait (index 0..2);
//   always ready, other indexes are ignored. Write only while idle.
// Timing:
//   The sequencer state and the result register are updated in the cycle
//   an item is accepted; its result is valid from the next cycle.
//   One item per cycle sustained: req_ready is high while the result
//   register is empty or is being taken in the same cycle.
// Reset:
//   Synchronous; clears the sequencer to idle with all pins low and
//   reloads the wait registers with 500, 100 and 1000.
// Stall:
//   While rsp_ready is low a pending result holds and req_ready drops,
//   so the sequencer does not advance.
`default_nettype none
`include "assert_macros.svh"

module lcd_nibble_write_sequencer_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire lcdnws_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output lcdnws_pkg::rsp_type    rsp_payload,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [15:0]       csr_wdata
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_SETUP, PH_HI_ON, PH_HI_OFF,
      PH_LO_ON, PH_LO_OFF, PH_INIT_ON, PH_INIT_OFF
   } phase_type;

   logic [15:0] setup_wait_ff, strobe_wait_ff, init_wait_ff;

   phase_type   phase_ff, phase_in;
   logic [15:0] wait_ff, wait_in;
   logic [7:0]  byte_ff, byte_in;
   logic        rs_ff, rs_in;
   logic        enable_ff, enable_in;
   logic [3:0]  nibble_ff, nibble_in;
   logic        entry_ff, entry_in;
   logic [3:0]  step_ff, step_in;

   logic                rsp_valid_ff;
   lcdnws_pkg::rsp_type rsp_ff, rsp_in;

   logic req_fire;
   logic refused;
   logic accepted;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      phase_in  = phase_ff;
      wait_in   = wait_ff;
      byte_in   = byte_ff;
      rs_in     = rs_ff;
      enable_in = enable_ff;
      nibble_in = nibble_ff;
      entry_in  = entry_ff;
      step_in   = step_ff;
      refused   = 1'b0;
      accepted  = 1'b0;

      if (req_payload.mode != lcdnws_pkg::MODE_TICK) begin
         if (phase_ff != PH_IDLE) begin
            refused = 1'b1;
         end else begin
            case (req_payload.mode)
               lcdnws_pkg::MODE_CMD: begin
                  byte_in   = req_payload.value;
                  rs_in     = 1'b0;
                  enable_in = 1'b0;
                  phase_in  = PH_SETUP;
                  wait_in   = setup_wait_ff;
                  accepted  = 1'b1;
               end
               lcdnws_pkg::MODE_DATA: begin
                  if (req_payload.value == lcdnws_pkg::CHAR_NL) begin
                     byte_in   = lcdnws_pkg::CMD_LINE2;
                     rs_in     = 1'b0;
                     enable_in = 1'b0;
                     phase_in  = PH_SETUP;
                     wait_in   = setup_wait_ff;
                     accepted  = 1'b1;
                  end else if (req_payload.value != lcdnws_pkg::CHAR_TERM) begin
                     entry_in  = 1'b1;
                     byte_in   = req_payload.value;
                     rs_in     = 1'b1;
                     enable_in = 1'b0;
                     phase_in  = PH_SETUP;
                     wait_in   = setup_wait_ff;
                     accepted  = 1'b1;
                  end
               end
               default: begin
                  rs_in     = 1'b0;
                  step_in   = lcdnws_pkg::STEP_FIRST;
                  entry_in  = 1'b0;
                  nibble_in = lcdnws_pkg::NIB_INIT_A;
                  enable_in = 1'b1;
                  phase_in  = PH_INIT_ON;
                  wait_in   = init_wait_ff;
                  accepted  = 1'b1;
               end
            endcase
         end
      end

      if (!accepted && phase_ff != PH_IDLE) begin
         if (wait_ff != 16'd0) begin
            wait_in = wait_ff - 16'd1;
         end else begin
            unique case (phase_ff)
               PH_SETUP: begin
                  nibble_in = byte_ff[7:4];
                  enable_in = 1'b1;
                  phase_in  = PH_HI_ON;
                  wait_in   = strobe_wait_ff;
               end
               PH_HI_ON: begin
                  enable_in = 1'b0;
                  phase_in  = PH_HI_OFF;
                  wait_in   = strobe_wait_ff;
               end
               PH_HI_OFF: begin
                  nibble_in = byte_ff[3:0];
                  enable_in = 1'b1;
                  phase_in  = PH_LO_ON;
                  wait_in   = strobe_wait_ff;
               end
               PH_LO_ON: begin
                  enable_in = 1'b0;
                  phase_in  = PH_LO_OFF;
                  wait_in   = strobe_wait_ff;
               end
               PH_LO_OFF: begin
                  if (entry_ff) begin
                     entry_in  = 1'b0;
                     byte_in   = lcdnws_pkg::CMD_ENTRY;
                     rs_in     = 1'b0;
                     enable_in = 1'b0;
                     phase_in  = PH_SETUP;
                     wait_in   = setup_wait_ff;
                  end else if (step_ff >= lcdnws_pkg::STEP_CMD0
                               && step_ff < lcdnws_pkg::STEP_CMDEND) begin
                     step_in   = step_ff + 4'd1;
                     byte_in   = lcdnws_pkg::init_cmd(step_ff + 4'd1);
                     rs_in     = 1'b0;
                     enable_in = 1'b0;
                     phase_in  = PH_SETUP;
                     wait_in   = setup_wait_ff;
                  end else begin
                     step_in  = lcdnws_pkg::STEP_NONE;
                     phase_in = PH_IDLE;
                     wait_in  = 16'd0;
                  end
               end
               PH_INIT_ON: begin
                  enable_in = 1'b0;
                  phase_in  = PH_INIT_OFF;
                  wait_in   = (step_ff == lcdnws_pkg::STEP_LASTNB) ? init_wait_ff : 16'd0;
               end
               PH_INIT_OFF: begin
                  if (step_ff < lcdnws_pkg::STEP_LASTNB) begin
                     step_in   = step_ff + 4'd1;
                     nibble_in = (step_ff + 4'd1 == lcdnws_pkg::STEP_LASTNB)
                                 ? lcdnws_pkg::NIB_INIT_B : lcdnws_pkg::NIB_INIT_A;
                     enable_in = 1'b1;
                     phase_in  = PH_INIT_ON;
                     wait_in   = init_wait_ff;
                  end else begin
                     step_in   = lcdnws_pkg::STEP_CMD0;
                     byte_in   = lcdnws_pkg::init_cmd(lcdnws_pkg::STEP_CMD0);
                     rs_in     = 1'b0;
                     enable_in = 1'b0;
                     phase_in  = PH_SETUP;
                     wait_in   = setup_wait_ff;
                  end
               end
               default: begin
                  step_in  = lcdnws_pkg::STEP_NONE;
                  entry_in = 1'b0;
                  phase_in = PH_IDLE;
                  wait_in  = 16'd0;
               end
            endcase
         end
      end

      rsp_in.reg_select = rs_in;
      rsp_in.enable_pin = enable_in;
      rsp_in.bus_nibble = nibble_in;
      rsp_in.busy_res   = (phase_in != PH_IDLE);
      rsp_in.refused    = refused;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_wait_ff  <= lcdnws_pkg::SETUP_WAIT_RESET;
         strobe_wait_ff <= lcdnws_pkg::STROBE_WAIT_RESET;
         init_wait_ff   <= lcdnws_pkg::INIT_WAIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lcdnws_pkg::CSR_SETUP_WAIT:  setup_wait_ff  <= csr_wdata;
            lcdnws_pkg::CSR_STROBE_WAIT: strobe_wait_ff <= csr_wdata;
            lcdnws_pkg::CSR_INIT_WAIT:   init_wait_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         wait_ff      <= 16'd0;
         byte_ff      <= 8'd0;
         rs_ff        <= 1'b0;
         enable_ff    <= 1'b0;
         nibble_ff    <= 4'd0;
         entry_ff     <= 1'b0;
         step_ff      <= lcdnws_pkg::STEP_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff  <= phase_in;
            wait_ff   <= wait_in;
            byte_ff   <= byte_in;
            rs_ff     <= rs_in;
            enable_ff <= enable_in;
            nibble_ff <= nibble_in;
            entry_ff  <= entry_in;
            step_ff   <= step_in;
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   `ASSERT_IMPLY(a_idle_clean, clock, reset, phase_ff == PH_IDLE,
      wait_ff == 16'd0 && step_ff == lcdnws_pkg::STEP_NONE && !entry_ff)
   `ASSERT_NEXT(a_fire_result, clock, reset, req_fire, rsp_valid_ff)
   `ASSERT_IMPLY(a_busy_matches, clock, reset, rsp_valid_ff,
      rsp_ff.busy_res == (phase_ff != PH_IDLE))

endmodule

`default_nettype wire

// ----- tb/tb_lcd_nibble_write_sequencer_core.sv -----
// Testbench for the LCD nibble write sequencer: directed plan, random requests, pin check
`timescale 1ns / 100ps

module tb_lcd_nibble_write_sequencer_core;
   import lcdnws_pkg::*;

   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int PLAN_ROWS = 34;

   localparam logic [4:0][7:0] INIT_CMDS =
      {CMD_DISP_ON, CMD_ENTRY, CMD_CLEAR, CMD_DISP_OFF, CMD_FUNC_SET};

   localparam rsp_type RSP_QUIET   = '{1'b0, 1'b0, 4'h0, 1'b0, 1'b0};
   localparam rsp_type RSP_BUSY    = '{1'b0, 1'b0, 4'h0, 1'b1, 1'b0};
   localparam rsp_type RSP_DROP    = '{1'b0, 1'b0, 4'h0, 1'b1, 1'b1};
   localparam rsp_type RSP_INIT_GO = '{1'b0, 1'b1, NIB_INIT_A, 1'b1, 1'b0};

   typedef enum logic [2:0] {
      SEQ_IDLE, SEQ_SETUP, SEQ_HI_ON, SEQ_HI_OFF,
      SEQ_LO_ON, SEQ_LO_OFF, SEQ_INIT_ON, SEQ_INIT_OFF
   } seq_phase_type;

   typedef enum logic [1:0] {ROW_ITEM, ROW_CSR, ROW_SETTLE} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [1:0]   sel;
      logic [15:0]  data;
      logic         typed;
      rsp_type      want;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_SETUP_WAIT;
   logic [15:0] csr_wdata = '0;

   int unsigned  send_gap_pct = 0;
   int unsigned  recv_stall_pct = 0;
   int           error_count = 0;
   rsp_type      expected_pins [$];
   rsp_type      seen_want;
   plan_row_type plan [0:PLAN_ROWS-1];

   logic [15:0] cfg_setup_wait  = SETUP_WAIT_RESET;
   logic [15:0] cfg_strobe_wait = STROBE_WAIT_RESET;
   logic [15:0] cfg_init_wait   = INIT_WAIT_RESET;

   seq_phase_type seq_phase = SEQ_IDLE;
   logic [15:0]   seq_wait = '0;
   logic [7:0]    seq_byte = '0;
   logic          seq_rs = 1'b0;
   logic          seq_en = 1'b0;
   logic [3:0]    seq_nib = '0;
   logic          seq_entry_due = 1'b0;
   logic [3:0]    seq_init_step = STEP_NONE;

   lcd_nibble_write_sequencer_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic logic [7:0] rand_byte();
      logic [31:0] r;
      r = $urandom;
      return r[7:0];
   endfunction

   function automatic void enter_phase(input seq_phase_type ph, input logic [15:0] w);
      seq_phase = ph;
      seq_wait  = w;
   endfunction

   function automatic void load_byte(input logic rs, input logic [7:0] b);
      seq_byte = b;
      seq_rs   = rs;
      seq_en   = 1'b0;
      enter_phase(SEQ_SETUP, cfg_setup_wait);
   endfunction

   function automatic void end_byte();
      if (seq_entry_due) begin
         seq_entry_due = 1'b0;
         load_byte(1'b0, CMD_ENTRY);
      end else if (seq_init_step >= STEP_CMD0 && seq_init_step < STEP_CMDEND) begin
         seq_init_step = seq_init_step + 4'd1;
         load_byte(1'b0, INIT_CMDS[seq_init_step - STEP_CMD0]);
      end else begin
         seq_init_step = STEP_NONE;
         enter_phase(SEQ_IDLE, '0);
      end
   endfunction

   function automatic void advance_sequence();
      if (seq_phase == SEQ_IDLE) return;
      if (seq_wait != '0) begin
         seq_wait = seq_wait - 16'd1;
         return;
      end
      case (seq_phase)
         SEQ_SETUP: begin
            seq_nib = seq_byte[7:4];
            seq_en  = 1'b1;
            enter_phase(SEQ_HI_ON, cfg_strobe_wait);
         end
         SEQ_HI_ON: begin
            seq_en = 1'b0;
            enter_phase(SEQ_HI_OFF, cfg_strobe_wait);
         end
         SEQ_HI_OFF: begin
            seq_nib = seq_byte[3:0];
            seq_en  = 1'b1;
            enter_phase(SEQ_LO_ON, cfg_strobe_wait);
         end
         SEQ_LO_ON: begin
            seq_en = 1'b0;
            enter_phase(SEQ_LO_OFF, cfg_strobe_wait);
         end
         SEQ_LO_OFF: end_byte();
         SEQ_INIT_ON: begin
            seq_en = 1'b0;
            enter_phase(SEQ_INIT_OFF, (seq_init_step == STEP_LASTNB) ? cfg_init_wait : 16'd0);
         end
         SEQ_INIT_OFF: begin
            if (seq_init_step < STEP_LASTNB) begin
               seq_init_step = seq_init_step + 4'd1;
               seq_nib = (seq_init_step == STEP_LASTNB) ? NIB_INIT_B : NIB_INIT_A;
               seq_en  = 1'b1;
               enter_phase(SEQ_INIT_ON, cfg_init_wait);
            end else begin
               seq_init_step = STEP_CMD0;
               load_byte(1'b0, INIT_CMDS[0]);
            end
         end
         default: begin
            seq_init_step = STEP_NONE;
            seq_entry_due = 1'b0;
            enter_phase(SEQ_IDLE, '0);
         end
      endcase
   endfunction

   function automatic rsp_type next_pins(input req_type item);
      rsp_type pins;
      logic    started;
      started      = 1'b0;
      pins.refused = 1'b0;
      if (item.mode != MODE_TICK) begin
         if (seq_phase != SEQ_IDLE) begin
            pins.refused = 1'b1;
         end else begin
            case (item.mode)
               MODE_CMD: begin
                  load_byte(1'b0, item.value);
                  started = 1'b1;
               end
               MODE_DATA: begin
                  if (item.value == CHAR_NL) begin
                     load_byte(1'b0, CMD_LINE2);
                     started = 1'b1;
                  end else if (item.value != CHAR_TERM) begin
                     seq_entry_due = 1'b1;
                     load_byte(1'b1, item.value);
                     started = 1'b1;
                  end
               end
               default: begin
                  seq_rs        = 1'b0;
                  seq_init_step = STEP_FIRST;
                  seq_entry_due = 1'b0;
                  seq_nib       = NIB_INIT_A;
                  seq_en        = 1'b1;
                  enter_phase(SEQ_INIT_ON, cfg_init_wait);
                  started = 1'b1;
               end
            endcase
         end
      end
      if (!started) advance_sequence();
      pins.reg_select = seq_rs;
      pins.enable_pin = seq_en;
      pins.bus_nibble = seq_nib;
      pins.busy_res   = (seq_phase != SEQ_IDLE);
      return pins;
   endfunction

   function automatic req_type pick_request();
      req_type     item;
      logic [31:0] r;
      r          = $urandom;
      item.value = r[7:0];
      item.mode  = MODE_TICK;
      if (seq_phase == SEQ_IDLE) begin
         case ($urandom_range(9))
            0:       item.mode = MODE_TICK;
            1, 2, 3: item.mode = MODE_CMD;
            9:       item.mode = MODE_INIT;
            default: item.mode = MODE_DATA;
         endcase
      end else if ($urandom_range(15) == 0) begin
         item.mode = r[9:8];
      end
      if (item.mode == MODE_DATA) begin
         case (r[14:12])
            3'd0:    item.value = CHAR_NL;
            3'd1:    item.value = CHAR_TERM;
            default: ;
         endcase
      end
      return item;
   endfunction

   task automatic send_item(input req_type item, input logic typed, input rsp_type want);
      rsp_type pins;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pins = next_pins(item);
      expected_pins.push_back(typed ? want : pins);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_pins.size() != 0) @(posedge clock);
   endtask

   task automatic settle_sequence();
      req_type tick;
      tick.mode = MODE_TICK;
      while (seq_phase != SEQ_IDLE) begin
         tick.value = rand_byte();
         send_item(tick, 1'b0, RSP_QUIET);
      end
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (index)
         CSR_SETUP_WAIT:  cfg_setup_wait  = data;
         CSR_STROBE_WAIT: cfg_strobe_wait = data;
         CSR_INIT_WAIT:   cfg_init_wait   = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pins.size() == 0) begin
            $display("%0t: result %h with none expected", $time, rsp_payload);
            error_count++;
         end else begin
            seen_want = expected_pins.pop_front();
            if (rsp_payload !== seen_want) begin
               $display("%0t: result expected %h actual %h", $time, seen_want, rsp_payload);
               error_count++;
            end
         end
      end
   end

   initial begin
      #40_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      int          row_idx;
      int          lap;
      int          active;
      int unsigned wait_cap;
      req_type     item;

      plan[0]  = '{ROW_ITEM, MODE_TICK, 16'h00FF, 1'b1, RSP_QUIET};
      plan[1]  = '{ROW_ITEM, MODE_DATA, 16'h0000, 1'b1, RSP_QUIET};
      plan[2]  = '{ROW_CSR, CSR_SETUP_WAIT, 16'h0003, 1'b0, RSP_QUIET};
      plan[3]  = '{ROW_CSR, CSR_STROBE_WAIT, 16'h0001, 1'b0, RSP_QUIET};
      plan[4]  = '{ROW_CSR, CSR_INIT_WAIT, 16'h0002, 1'b0, RSP_QUIET};
      plan[5]  = '{ROW_ITEM, MODE_CMD, 16'h00FF, 1'b1, RSP_BUSY};
      plan[6]  = '{ROW_ITEM, MODE_DATA, 16'h0041, 1'b1, RSP_DROP};
      plan[7]  = '{ROW_ITEM, MODE_INIT, 16'h0000, 1'b1, RSP_DROP};
      plan[8]  = '{ROW_ITEM, MODE_CMD, 16'h0000, 1'b1, RSP_DROP};
      plan[9]  = '{ROW_SETTLE, MODE_TICK, 16'h0000, 1'b0, RSP_QUIET};
      plan[10] = '{ROW_CSR, CSR_SETUP_WAIT, 16'h0000, 1'b0, RSP_QUIET};
      plan[11] = '{ROW_CSR, CSR_STROBE_WAIT, 16'h0000, 1'b0, RSP_QUIET};
      plan[12] = '{ROW_CSR, CSR_INIT_WAIT, 16'h0000, 1'b0, RSP_QUIET};
      plan[13] = '{ROW_ITEM, MODE_INIT, 16'h00FF, 1'b1, RSP_INIT_GO};
      plan[14] = '{ROW_ITEM, MODE_TICK, 16'h0000, 1'b0, RSP_QUIET};
      plan[15] = '{ROW_ITEM, MODE_CMD, 16'h00FF, 1'b0, RSP_QUIET};
      plan[16] = '{ROW_SETTLE, MODE_TICK, 16'h0000, 1'b0, RSP_QUIET};
      plan[17] = '{ROW_ITEM, MODE_DATA, {8'h00, CHAR_NL}, 1'b0, RSP_QUIET};
      plan[18] = '{ROW_SETTLE, MODE_TICK, 16'h0000, 1'b0, RSP_QUIET};
      plan[19] = '{ROW_ITEM, MODE_DATA, 16'h00FF, 1'b0, RSP_QUIET};
      plan[20] = '{ROW_SETTLE, MODE_TICK, 16'h0000, 1'b0, RSP_QUIET};
      plan[21] = '{ROW_CSR, CSR_SETUP_WAIT, 16'h0003, 1'b0, RSP_QUIET};
      plan[22] = '{ROW_CSR, CSR_STROBE_WAIT, 16'h0001, 1'b0, RSP_QUIET};
      plan[23] = '{ROW_CSR, CSR_INIT_WAIT, 16'h0002, 1'b0, RSP_QUIET};
      plan[24] = '{ROW_ITEM, MODE_CMD, 16'h005A, 1'b0, RSP_QUIET};
      plan[25] = '{ROW_CSR, CSR_STROBE_WAIT, 16'h0002, 1'b0, RSP_QUIET};
      plan[26] = '{ROW_ITEM, MODE_INIT, 16'h0000, 1'b0, RSP_QUIET};
      plan[27] = '{ROW_SETTLE, MODE_TICK, 16'h0000, 1'b0, RSP_QUIET};
      plan[28] = '{ROW_CSR, CSR_UNUSED, 16'hFFFF, 1'b0, RSP_QUIET};
      plan[29] = '{ROW_ITEM, MODE_INIT, 16'h0000, 1'b0, RSP_QUIET};
      plan[30] = '{ROW_SETTLE, MODE_TICK, 16'h0000, 1'b0, RSP_QUIET};
      plan[31] = '{ROW_ITEM, MODE_DATA, 16'h00A5, 1'b0, RSP_QUIET};
      plan[32] = '{ROW_ITEM, MODE_CMD, 16'h0000, 1'b0, RSP_QUIET};
      plan[33] = '{ROW_SETTLE, MODE_TICK, 16'h0000, 1'b0, RSP_QUIET};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (row_idx = 0; row_idx < PLAN_ROWS; row_idx++) begin
         case (plan[row_idx].kind)
            ROW_ITEM: begin
               item.mode  = plan[row_idx].sel;
               item.value = plan[row_idx].data[7:0];
               send_item(item, plan[row_idx].typed, plan[row_idx].want);
            end
            ROW_CSR: begin
               wait_drained();
               csr_write(plan[row_idx].sel, plan[row_idx].data);
            end
            default: settle_sequence();
         endcase
      end

      for (lap = 0; lap < 4; lap++) begin
         settle_sequence();
         wait_drained();
         case (lap)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  wait_cap = 2; end
            1: begin send_gap_pct = 72; recv_stall_pct = 0;  wait_cap = 3; end
            2: begin send_gap_pct = 0;  recv_stall_pct = 72; wait_cap = 1; end
            default: begin send_gap_pct = 38; recv_stall_pct = 38; wait_cap = 4; end
         endcase
         csr_write(CSR_SETUP_WAIT, 16'($urandom_range(wait_cap)));
         csr_write(CSR_STROBE_WAIT, 16'($urandom_range(wait_cap)));
         csr_write(CSR_INIT_WAIT, 16'($urandom_range(wait_cap)));
         active = 0;
         while (active < 50) begin
            item = pick_request();
            if (!(seq_phase == SEQ_IDLE && (item.mode == MODE_TICK ||
                  (item.mode == MODE_DATA && item.value == CHAR_TERM))))
               active++;
            send_item(item, 1'b0, RSP_QUIET);
            if ($urandom_range(39) == 0) wait_drained();
         end
      end

      settle_sequence();
      wait_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_pins.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
